/* rtl/smrc_pkg.sv */
package smrc_pkg;
	localparam logic [2:0] ACT_CONFIG  = 3'd0;
	localparam logic [2:0] ACT_SERVICE = 3'd1;
	localparam logic [2:0] ACT_POINT   = 3'd2;
	localparam logic [2:0] ACT_CLOSE   = 3'd3;
	localparam logic [2:0] ACT_OPEN    = 3'd4;
	localparam logic [2:0] ACT_TICK    = 3'd5;
	localparam logic [2:0] ACT_LIMIT   = 3'd6;

	localparam logic [15:0] DIR_PLUS  = 16'd1;
	localparam logic [15:0] DIR_MINUS = 16'd2;

	localparam logic REG_ACTIVE = 1'b0;
	localparam logic REG_PTIME  = 1'b1;

	typedef struct packed {
		logic [14:0] cur;
		logic [14:0] tgt;
		logic [15:0] step;
		logic [14:0] mainp;
		logic [14:0] sidep;
		logic        en;
		logic        svc;
		logic        msw;
		logic        osw;
		logic        bar;
	} chan_t;

	typedef struct packed {
		logic        start;
		logic [31:0] dividend;
		logic [15:0] divisor;
	} div_req_t;
endpackage

/* rtl/smrc_divider.sv */
// Restoring divider, sign-magnitude, one quotient bit per cycle.
module smrc_divider
	import smrc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  div_req_t    req,
	output logic        done,
	output logic [15:0] quotient
);
	logic [15:0] rem_q, quo_q, den_q;
	logic        neg_q, busy_q;
	logic [4:0]  cnt_q;
	logic [16:0] trial;

	assign trial = {rem_q, quo_q[15]} - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'd16;
				neg_q  <= req.dividend[31];
				quo_q  <= req.dividend[31] ? 16'(-req.dividend) : req.dividend[15:0];
				rem_q  <= '0;
				den_q  <= req.divisor;
			end else if (busy_q) begin
				if (!trial[16]) begin
					rem_q <= trial[15:0];
					quo_q <= {quo_q[14:0], 1'b1};
				end else begin
					rem_q <= {rem_q[14:0], quo_q[15]};
					quo_q <= {quo_q[14:0], 1'b0};
				end
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd1) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	assign quotient = neg_q ? 16'(-quo_q) : quo_q;
endmodule

/* rtl/smrc_chan_ram.sv */
// Channel table, one write and one registered read port.
module smrc_chan_ram
	import smrc_pkg::*;
#(
	parameter int CHANNELS = 16
) (
	input  logic                        clk,
	input  logic                        we,
	input  logic [$clog2(CHANNELS)-1:0] waddr,
	input  chan_t                       wdata,
	input  logic [$clog2(CHANNELS)-1:0] raddr,
	output chan_t                       rdata
);
	chan_t mem [CHANNELS];
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

/* rtl/servo_move_ramp_controller.sv */
// Channel   | Direction | Handshake
// in_*      | input     | in_valid / in_ready
// out_*     | output    | out_valid / out_ready
// cfg       | input     | cfg_we, no wait
// Each request is read from the channel RAM (registered read), modified and
// written back. Moves wait in ST_DIV for the divider before write-back.
// A tick walks the active channels one at a time, holding on out_ready.
// Reset clears the control registers and runs a clearing pass over every
// RAM entry before the first request is taken. A stalled result holds.
module servo_move_ramp_controller
	import smrc_pkg::*;
#(
	parameter int CHANNELS = 16,
	parameter int FRAME_MS = 20
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  action,
	input  logic [3:0]  channel,
	input  logic [15:0] value,
	input  logic [14:0] side_value,
	input  logic        set_is_barrier,
	input  logic        main_switch,
	input  logic        other_switch,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        kind,
	output logic [3:0]  out_channel,
	output logic [14:0] position,
	output logic        enabled,
	output logic [1:0]  limit_state,
	output logic        report_is_barrier,
	output logic        last,
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	localparam int AW = $clog2(CHANNELS) > 0 ? $clog2(CHANNELS) : 1;
	localparam logic [2:0] ST_CLR = 3'd0, ST_IDLE = 3'd1, ST_READ = 3'd2,
		ST_EXEC = 3'd3, ST_DIV = 3'd4, ST_OUT = 3'd5;
	// frames = time / FRAME_MS by reciprocal multiply, exact for 16-bit times
	localparam int FRAME_SH = 16 + $clog2(FRAME_MS);
	localparam logic [16:0] FRAME_RECIP =
		17'(((64'd1 << FRAME_SH) + 64'(FRAME_MS) - 64'd1) / 64'(FRAME_MS));

	logic [2:0]  state_q;
	logic [4:0]  active_q;
	logic [15:0] ptime_q;
	logic [6:0]  n_act;
	logic [AW-1:0] addr_q;
	logic [2:0]  act_q;
	logic [15:0] val_q;
	logic [14:0] side_q;
	logic        bar_q, msw_q, osw_q;
	chan_t       rd, ent_q, wd;
	logic        we;
	logic [AW-1:0] waddr;
	div_req_t    dreq;
	logic        ddone;
	logic [15:0] dquo;
	logic [14:0] mtgt_q;

	smrc_chan_ram #(.CHANNELS(CHANNELS)) u_ram (
		.clk, .we, .waddr, .wdata(wd), .raddr(addr_q), .rdata(rd));
	smrc_divider u_div (.clk, .arst_n, .req(dreq), .done(ddone), .quotient(dquo));

	assign n_act = (7'(active_q) > 7'(CHANNELS)) ? 7'(CHANNELS) : 7'(active_q);
	assign in_ready = (state_q == ST_IDLE);

	// move parameters from the entry just read
	logic [15:0] mtime;
	logic [14:0] mtgt;
	logic [15:0] frames;
	logic [39:0] fprod;
	always_comb begin
		mtgt  = (act_q == ACT_CLOSE || (act_q == ACT_POINT && val_q == DIR_MINUS)) ?
			rd.sidep : rd.mainp;
		mtime = (act_q == ACT_POINT) ? ptime_q : val_q;
		fprod = {24'b0, mtime} * {23'b0, FRAME_RECIP};
		frames = fprod[FRAME_SH +: 16];
		if (frames == 16'd0) frames = 16'd1;
	end

	// tick advance
	chan_t adv;
	logic [16:0] sum;
	always_comb begin
		adv = ent_q;
		sum = {2'b0, ent_q.cur} + {ent_q.step[15], ent_q.step};
		if (ent_q.cur != ent_q.tgt) begin
			if ((!ent_q.step[15] && sum >= {2'b0, ent_q.tgt}) ||
				(ent_q.step[15] && $signed(sum) <= $signed({2'b0, ent_q.tgt}))) begin
				adv.cur = ent_q.tgt;
				if (!ent_q.svc) adv.en = 1'b0;
			end else begin
				adv.cur = sum[14:0];
			end
		end
	end

	// sum compare above is exact: cur+step stays in 17-bit signed range
	always_comb begin
		dreq.start    = 1'b0;
		dreq.dividend = 32'(signed'({17'b0, mtgt}) - signed'({17'b0, rd.cur}));
		dreq.divisor  = frames;
		if (state_q == ST_EXEC &&
			(act_q == ACT_CLOSE || act_q == ACT_OPEN ||
			 (act_q == ACT_POINT && (val_q == DIR_PLUS || val_q == DIR_MINUS))))
			dreq.start = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLR;
			addr_q    <= '0;
			active_q  <= '0;
			ptime_q   <= 16'd1000;
			out_valid <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_ACTIVE) active_q <= cfg_data[4:0];
				else ptime_q <= cfg_data;
			end
			if (out_valid && out_ready) out_valid <= 1'b0;
			case (state_q)
				ST_CLR: begin
					addr_q <= addr_q + AW'(1);
					if (32'(addr_q) == CHANNELS - 1) begin
						addr_q  <= '0;
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_valid) begin
						act_q <= action; val_q <= value; side_q <= side_value;
						bar_q <= set_is_barrier; msw_q <= main_switch;
						osw_q <= other_switch;
						addr_q <= (action == ACT_TICK) ? '0 : AW'(channel);
						if (action == ACT_CONFIG)
							state_q <= (32'(channel) < CHANNELS) ? ST_READ : ST_IDLE;
						else if (action == ACT_TICK)
							state_q <= (n_act != 0) ? ST_READ : ST_IDLE;
						else
							state_q <= (7'(channel) < n_act) ? ST_READ : ST_IDLE;
					end
				end
				ST_READ: state_q <= ST_EXEC;
				ST_EXEC: begin
					ent_q  <= rd;
					mtgt_q <= mtgt;
					if (dreq.start) state_q <= ST_DIV;
					else if (act_q == ACT_TICK) state_q <= ST_OUT;
					else if (act_q == ACT_LIMIT &&
						(rd.msw != msw_q || rd.osw != osw_q)) state_q <= ST_OUT;
					else state_q <= ST_IDLE;
				end
				ST_DIV: if (ddone) state_q <= ST_IDLE;
				ST_OUT: begin
					if (!out_valid || out_ready) begin
						out_valid <= 1'b1;
						kind <= (act_q == ACT_LIMIT);
						out_channel <= 4'(addr_q);
						position <= wd.cur;
						enabled <= wd.en;
						limit_state <= {wd.osw, wd.msw};
						report_is_barrier <= wd.bar;
						last <= (act_q == ACT_LIMIT) || (7'(addr_q) + 7'd1 == n_act);
						if (act_q == ACT_TICK && 7'(addr_q) + 7'd1 != n_act) begin
							addr_q  <= addr_q + AW'(1);
							state_q <= ST_READ;
						end else state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// write-back
	always_comb begin
		we    = 1'b0;
		waddr = addr_q;
		wd    = rd;
		case (state_q)
			ST_CLR: begin
				we = 1'b1;
				wd = '0;
			end
			ST_EXEC: begin
				case (act_q)
					ACT_CONFIG: begin
						we = 1'b1;
						wd.mainp = val_q[14:0]; wd.sidep = side_q;
						wd.cur = val_q[14:0]; wd.tgt = val_q[14:0];
						wd.step = '0; wd.en = 1'b1; wd.svc = 1'b0; wd.bar = bar_q;
					end
					ACT_SERVICE: begin
						we = 1'b1;
						wd.cur = val_q[15] ? 15'h7FFF : val_q[14:0];
						wd.tgt = wd.cur; wd.step = '0;
						wd.svc = 1'b1; wd.en = 1'b1;
					end
					default: ;
				endcase
			end
			ST_DIV: begin
				wd = ent_q;
				wd.step = dquo; wd.tgt = mtgt_q;
				wd.svc = 1'b0; wd.en = (dquo != 16'd0);
				we = ddone;
			end
			ST_OUT: begin
				if (act_q == ACT_TICK) wd = adv;
				else begin
					wd = ent_q;
					wd.msw = msw_q; wd.osw = osw_q;
					if ((msw_q || osw_q) && !ent_q.svc) begin
						wd.en = 1'b0; wd.tgt = ent_q.cur; wd.step = '0;
					end
				end
				we = (!out_valid || out_ready);
			end
			default: ;
		endcase
	end
endmodule
